FILE: hw/rtl/raycast_wall_column_setup_top_macros.svh
// assertion macros for the wall column setup block
// used by the top level only
`ifndef RAYCAST_WALL_COLUMN_SETUP_TOP_MACROS_SVH
`define RAYCAST_WALL_COLUMN_SETUP_TOP_MACROS_SVH
`define RCW_ASSERT_IMP(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
`define RCW_ASSERT_NXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`endif

FILE: hw/rtl/rcw_pkg.sv
// shared types and constants for the wall column setup block
// no dependencies
package rcw_pkg;
	localparam int SCREEN_ROWS_DEF = 512;
	localparam int DIV_STAGES = 17;
	localparam logic [12:0] TEX_W_RESET = 13'd64;
	localparam logic [12:0] TEX_W_MAX = 13'd4096;
	localparam logic [0:0] REG_TEX_W = 1'b0;

	typedef struct packed {
		logic        hit_side;
		logic [30:0] side_dist_x;
		logic [30:0] side_dist_y;
		logic [30:0] delta_dist_x;
		logic [30:0] delta_dist_y;
		logic [31:0] ray_dir_x;
		logic [31:0] ray_dir_y;
		logic [30:0] player_x;
		logic [30:0] player_y;
	} ray_t;

	typedef struct packed {
		logic [31:0] perp_distance;
		logic [15:0] line_height;
		logic [9:0]  draw_start;
		logic [9:0]  draw_end;
		logic [11:0] texture_column;
	} slice_t;

	// classified item handed from front to back
	typedef struct packed {
		logic [31:0] perp;
		logic        pos_ok;
		logic [31:0] frac;
		logic [12:0] width;
		logic        mirror;
	} job_t;
endpackage

FILE: hw/rtl/rcw_stream_if.sv
// valid/ready channel carrying one payload type
// depends on nothing but the payload type parameter
interface rcw_stream_if #(parameter type T = logic) (input logic clk);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/rcw_front.sv
// front: distance, hit fraction and mirror decision, two stages
// depends on rcw_pkg
module rcw_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [12:0]     tex_w,
	input  logic            in_valid,
	output logic            in_ready,
	input  rcw_pkg::ray_t   in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output rcw_pkg::job_t   out_data
);
	import rcw_pkg::*;

	logic        v_s1, v_s2;
	logic        adv1, adv2;
	logic [31:0] perp_s1;
	logic [31:0] dir_s1;
	logic [30:0] pos_s1;
	logic [12:0] w_s1;
	logic        mir_s1;
	logic [31:0] perp_c;
	logic [12:0] w_c;
	logic [63:0] prod_s2;
	job_t        job_s2;
	logic [31:0] frac_c;

	assign adv2 = !v_s2 || out_ready;
	assign adv1 = !v_s1 || adv2;
	assign in_ready = adv1;

	assign perp_c = in_data.hit_side ?
		({1'b0, in_data.side_dist_y} - {1'b0, in_data.delta_dist_y}) :
		({1'b0, in_data.side_dist_x} - {1'b0, in_data.delta_dist_x});
	assign w_c = (tex_w == 13'd0) ? 13'd1 : ((tex_w > TEX_W_MAX) ? TEX_W_MAX : tex_w);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			perp_s1 <= perp_c;
			dir_s1 <= in_data.hit_side ? in_data.ray_dir_x : in_data.ray_dir_y;
			pos_s1 <= in_data.hit_side ? in_data.player_x : in_data.player_y;
			w_s1 <= w_c;
			mir_s1 <= in_data.hit_side ? in_data.ray_dir_y[31] :
				(!in_data.ray_dir_x[31] && (in_data.ray_dir_x != 32'd0));
		end
		if (adv2 && v_s1) begin
			prod_s2 <= $signed(perp_s1) * $signed(dir_s1);
			job_s2.perp <= perp_s1;
			job_s2.pos_ok <= !perp_s1[31] && (perp_s1 != 32'd0);
			job_s2.frac <= {pos_s1[15:0], 16'd0};
			job_s2.width <= w_s1;
			job_s2.mirror <= mir_s1;
		end
	end

	// fraction low 32 bits, then scaled by width in the back
	assign frac_c = prod_s2[31:0] + job_s2.frac;
	always_comb begin
		out_data = job_s2;
		out_data.frac = frac_c;
	end
	assign out_valid = v_s2;
endmodule

FILE: hw/rtl/rcw_fifo.sv
// short queue between front and back
// depends on nothing
module rcw_fifo #(
	parameter int W = 8,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [W-1:0] in_data,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [W-1:0] out_data
);
	localparam int AW = $clog2(DEPTH);
	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;
	logic          wr, rd;

	assign in_ready = cnt_q != (AW+1)'(DEPTH);
	assign out_valid = cnt_q != '0;
	assign out_data = mem_q[rp_q];
	assign wr = in_valid && in_ready;
	assign rd = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			if (rd) rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= in_data;
	end
endmodule

FILE: hw/rtl/rcw_back.sv
// back: pipelined restoring divider for the height, clamps and texel column
// depends on rcw_pkg
module rcw_back #(
	parameter int SCREEN_ROWS = rcw_pkg::SCREEN_ROWS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  rcw_pkg::job_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output rcw_pkg::slice_t out_data
);
	import rcw_pkg::*;

	// quotient of SCREEN_ROWS<<16 by perp saturates once >= 2^16,
	// so only 17 quotient bits are needed
	localparam int NB = DIV_STAGES;
	localparam logic [9:0] HALF = 10'(SCREEN_ROWS / 2);
	localparam logic [9:0] LAST = 10'(SCREEN_ROWS - 1);
	localparam logic [47:0] DIVIDEND = 48'(SCREEN_ROWS) << 16;

	logic          adv;
	logic          v_q [NB+1];
	logic [47:0]   rem_q [NB+1];
	logic [16:0]   quo_q [NB+1];
	logic [31:0]   dvs_q [NB+1];
	logic          pos_q [NB+1];
	logic [31:0]   perp_q [NB+1];
	logic [11:0]   col_q [NB+1];
	logic [44:0]   colp_s1;
	logic [12:0]   w_s1;
	logic          mir_s1;
	logic [11:0]   col_c;
	logic [15:0]   h;
	logic [9:0]    hh;
	slice_t        res_q;
	logic          rv_q;

	assign adv = !rv_q || out_ready;
	assign in_ready = adv;

	// stage 0 : scaled column product
	always_ff @(posedge clk) begin
		if (adv) begin
			colp_s1 <= in_data.frac * 45'(in_data.width);
			w_s1 <= in_data.width;
			mir_s1 <= in_data.mirror;
			rem_q[0] <= DIVIDEND;
			quo_q[0] <= '0;
			dvs_q[0] <= in_data.perp;
			pos_q[0] <= in_data.pos_ok;
			perp_q[0] <= in_data.perp;
		end
	end
	assign col_c = mir_s1 ? 12'(w_s1 - 13'(colp_s1[44:32]) - 13'd1) : colp_s1[43:32];

	always_comb begin
		col_q[0] = col_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= NB; i++) v_q[i] <= 1'b0;
			rv_q <= 1'b0;
		end else if (adv) begin
			v_q[0] <= in_valid;
			for (int i = 1; i <= NB; i++) v_q[i] <= v_q[i-1];
			rv_q <= v_q[NB];
		end
	end

	genvar g;
	generate
		for (g = 0; g < NB; g++) begin : g_div
			logic [47:0] trial;
			logic        ge;
			assign trial = {16'd0, dvs_q[g]} << (NB - 1 - g);
			assign ge = rem_q[g] >= trial;
			always_ff @(posedge clk) begin
				if (adv) begin
					rem_q[g+1] <= ge ? rem_q[g] - trial : rem_q[g];
					quo_q[g+1] <= {quo_q[g][15:0], ge};
					dvs_q[g+1] <= dvs_q[g];
					pos_q[g+1] <= pos_q[g];
					perp_q[g+1] <= perp_q[g];
					col_q[g+1] <= col_q[g];
				end
			end
		end
	endgenerate

	assign h = (!pos_q[NB] || quo_q[NB][16]) ? 16'hFFFF : quo_q[NB][15:0];
	assign hh = (h[15:1] > 15'(HALF)) ? HALF : 10'(h[15:1]);

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q.perp_distance <= perp_q[NB];
			res_q.line_height <= h;
			res_q.draw_start <= HALF - hh;
			res_q.draw_end <= ({1'b0, h[15:1]} + 16'(HALF) >= 16'(SCREEN_ROWS)) ?
				LAST : 10'(h[15:1] + 15'(HALF));
			res_q.texture_column <= col_q[NB];
		end
	end

	assign out_valid = rv_q;
	assign out_data = res_q;
endmodule

FILE: hw/rtl/raycast_wall_column_setup_top.sv
// Wall column setup for a grid raycaster: one finished ray in, one wall slice out.
// Throughput is one ray per cycle while the output is not stalled. A slice passes
// from the edge that accepts its ray through the two front stages, the queue,
// the divider's input stage, the 17-stage restoring divider for the slice height and
// the output register. A stalled output freezes the back; the queue lets the front
// run on until its four entries fill. texture_width is written over APB at address 0.
// depends on rcw_pkg, rcw_stream_if, rcw_front, rcw_fifo, rcw_back and the macros header
`include "raycast_wall_column_setup_top_macros.svh"
module raycast_wall_column_setup_top #(
	parameter int SCREEN_ROWS = rcw_pkg::SCREEN_ROWS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	rcw_stream_if.sink   ray,
	rcw_stream_if.source slice
);
	import rcw_pkg::*;

	logic [12:0] tex_w_q;
	logic        wr;
	logic        fv, fr, qv, qr;
	job_t        fd, qd;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == REG_TEX_W) ? {19'd0, tex_w_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) tex_w_q <= TEX_W_RESET;
		else if (wr && paddr[2] == REG_TEX_W) tex_w_q <= pwdata[12:0];
	end

	rcw_front u_front (
		.clk, .arst_n, .tex_w(tex_w_q),
		.in_valid(ray.valid), .in_ready(ray.ready), .in_data(ray.data),
		.out_valid(fv), .out_ready(fr), .out_data(fd)
	);

	rcw_fifo #(.W($bits(job_t)), .DEPTH(4)) u_fifo (
		.clk, .arst_n,
		.in_valid(fv), .in_ready(fr), .in_data(fd),
		.out_valid(qv), .out_ready(qr), .out_data(qd)
	);

	rcw_back #(.SCREEN_ROWS(SCREEN_ROWS)) u_back (
		.clk, .arst_n,
		.in_valid(qv), .in_ready(qr), .in_data(qd),
		.out_valid(slice.valid), .out_ready(slice.ready), .out_data(slice.data)
	);

	`RCW_ASSERT_IMP(a_start_le_end, clk, arst_n, slice.valid, slice.data.draw_start <= slice.data.draw_end)
	`RCW_ASSERT_IMP(a_col_range, clk, arst_n, slice.valid, 13'(slice.data.texture_column) < tex_w_q || tex_w_q == 13'd0 || tex_w_q > TEX_W_MAX)
	`RCW_ASSERT_NXT(a_width_write, clk, arst_n, wr && paddr[2] == REG_TEX_W, tex_w_q == $past(pwdata[12:0]))
endmodule
